// File: hw/rtl/tfd_pkg.sv
// Shared types, register indexes and constants for the tiled frame detiler.
package tfd_pkg;

  localparam int ADDR_W      = 28;  // covers the largest tiled address of any legal geometry
  localparam int COUNT_W     = 12;
  localparam int DIM_W       = 13;
  localparam int TOTAL_W     = 14;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 14;
  localparam int SAMPLE_W    = 8;
  localparam int WADDR_W     = 20;

  localparam logic [DIM_W-1:0]   DIM_MAX             = 13'd4096;
  localparam logic [DIM_W-1:0]   RESET_ACTIVE_WIDTH  = 13'd1920;
  localparam logic [DIM_W-1:0]   RESET_ACTIVE_HEIGHT = 13'd1080;
  localparam logic [TOTAL_W-1:0] RESET_TOTAL_WIDTH   = 14'd2048;

  localparam logic [CFG_INDEX_W-1:0] CFG_PLANE_MODE    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_ACTIVE_WIDTH  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_ACTIVE_HEIGHT = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_TOTAL_WIDTH   = 2'd3;

  localparam logic FUNC_WRITE  = 1'b0;
  localparam logic FUNC_READ   = 1'b1;
  localparam logic MODE_LUMA   = 1'b0;
  localparam logic MODE_CHROMA = 1'b1;

  typedef logic [ADDR_W-1:0] addr_t;

  typedef struct packed {
    addr_t addr;
    logic  eor;
    logic  eof;
    logic  oor;
  } scan_info_t;

  // Zero acts as one, anything past the counter reach saturates.
  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = 13'd1;
    end else if (v > DIM_MAX) begin
      r = DIM_MAX;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// File: hw/rtl/tfd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tfd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: hw/rtl/tfd_scan.sv
// Raster scan counters and tiled address generation.
module tfd_scan #(
  parameter int TILE_WIDTH_SHIFT  = 8,
  parameter int TILE_HEIGHT_SHIFT = 5,
  parameter int STORE_BYTES       = 1048576
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        plane_mode,
  input  logic [tfd_pkg::DIM_W-1:0]   active_width,
  input  logic [tfd_pkg::DIM_W-1:0]   active_height,
  input  logic [tfd_pkg::TOTAL_W-1:0] total_width,
  input  logic                        step,
  output tfd_pkg::scan_info_t         info
);
  import tfd_pkg::*;

  localparam int TILE_W = 1 << TILE_WIDTH_SHIFT;
  localparam int TILE_H = 1 << TILE_HEIGHT_SHIFT;

  logic [COUNT_W-1:0] column_count;
  logic [COUNT_W-1:0] row_count;

  logic [DIM_W-1:0] w_eff;
  logic [DIM_W-1:0] h_eff;
  logic [DIM_W-1:0] col_inc;
  logic [DIM_W-1:0] row_inc;
  logic [DIM_W-1:0] x;
  addr_t            term_tile;
  addr_t            stride;
  addr_t            term_row;
  addr_t            term_x;
  addr_t            term_y;
  addr_t            addr;
  addr_t            last;

  assign w_eff   = eff_dim(active_width);
  assign h_eff   = eff_dim(active_height);
  assign col_inc = {1'b0, column_count} + 13'd1;
  assign row_inc = {1'b0, row_count} + 13'd1;

  // chroma walks byte pairs, so the byte column is twice the pixel column
  assign x = (plane_mode == MODE_CHROMA) ? {column_count, 1'b0} : {1'b0, column_count};

  assign term_tile = addr_t'(x >> TILE_WIDTH_SHIFT) << (TILE_WIDTH_SHIFT + TILE_HEIGHT_SHIFT);
  assign stride    = addr_t'(row_count >> TILE_HEIGHT_SHIFT) * addr_t'(total_width);
  assign term_row  = stride << TILE_HEIGHT_SHIFT;
  assign term_x    = addr_t'(x & DIM_W'(TILE_W - 1));
  assign term_y    = addr_t'(row_count & COUNT_W'(TILE_H - 1)) << TILE_WIDTH_SHIFT;
  assign addr      = term_tile + term_row + term_x + term_y;
  assign last      = (plane_mode == MODE_CHROMA) ? addr + addr_t'(1) : addr;

  assign info.addr = addr;
  assign info.oor  = (last >= addr_t'(STORE_BYTES));
  assign info.eor  = (col_inc >= w_eff);
  assign info.eof  = info.eor && (row_inc >= h_eff);

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (step) begin
      if (info.eor) begin
        column_count <= '0;
        row_count    <= info.eof ? '0 : row_count + 12'd1;
      end else begin
        column_count <= column_count + 12'd1;
      end
    end
  end

endmodule

// File: hw/rtl/tiled_frame_detiler.sv
// Top level of the tiled frame detiler: config registers, pipeline and byte store.
//
//   channel  direction  handshake                  payload
//   cfg      in         cfg_write                  cfg_index, cfg_data
//   item     in         item_valid / item_ready    func, write_address, write_data
//   result   out        result_valid / result_ready first_sample, second_sample,
//                                                  end_of_row, end_of_frame, out_of_range
//
// One word per cycle in each direction while the result channel is not stalled; a read word's
// result passes the address register at accept, then the store read register, then the output register.
// The store is two byte banks (even and odd addresses), so a chroma pair is one read.
// Writes take effect in order with reads as they leave the address stage.
// Reset clears the counters and valid flags and loads the default config; the store holds garbage until written.
// A stalled result backs up through the stages; item_ready drops only when all are full.
module tiled_frame_detiler #(
  parameter int TILE_WIDTH_SHIFT  = 8,
  parameter int TILE_HEIGHT_SHIFT = 5,
  parameter int STORE_BYTES       = 1048576
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [tfd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [tfd_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            item_valid,
  output logic                            item_ready,
  input  logic                            func,
  input  logic [tfd_pkg::WADDR_W-1:0]     write_address,
  input  logic [tfd_pkg::SAMPLE_W-1:0]    write_data,
  output logic                            result_valid,
  input  logic                            result_ready,
  output logic [tfd_pkg::SAMPLE_W-1:0]    first_sample,
  output logic [tfd_pkg::SAMPLE_W-1:0]    second_sample,
  output logic                            end_of_row,
  output logic                            end_of_frame,
  output logic                            out_of_range
);
  import tfd_pkg::*;

  localparam int BANK_DEPTH = (STORE_BYTES + 1) / 2;
  localparam int BANK_AW    = $clog2(BANK_DEPTH);

  logic               plane_mode;
  logic [DIM_W-1:0]   active_width;
  logic [DIM_W-1:0]   active_height;
  logic [TOTAL_W-1:0] total_width;

  scan_info_t info;
  logic       item_take;
  logic       step;

  // address stage
  logic                s1_valid;
  logic                s1_write;
  addr_t               s1_addr;
  logic [SAMPLE_W-1:0] s1_data;
  logic                s1_eor;
  logic                s1_eof;
  logic                s1_oor;
  logic                s1_chroma;
  logic                s1_leave;

  // store read stage
  logic                s2_valid;
  logic                s2_eor;
  logic                s2_eof;
  logic                s2_oor;
  logic                s2_chroma;
  logic                s2_lsb;
  logic                s2_leave;
  logic                s2_load;

  logic [BANK_AW-1:0]  bank_addr;
  logic                even_we;
  logic                odd_we;
  logic                bank_re;
  logic [SAMPLE_W-1:0] even_q;
  logic [SAMPLE_W-1:0] odd_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      plane_mode    <= MODE_LUMA;
      active_width  <= RESET_ACTIVE_WIDTH;
      active_height <= RESET_ACTIVE_HEIGHT;
      total_width   <= RESET_TOTAL_WIDTH;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_PLANE_MODE:    plane_mode    <= cfg_data[0];
        CFG_ACTIVE_WIDTH:  active_width  <= cfg_data[DIM_W-1:0];
        CFG_ACTIVE_HEIGHT: active_height <= cfg_data[DIM_W-1:0];
        CFG_TOTAL_WIDTH:   total_width   <= cfg_data[TOTAL_W-1:0];
        default: ;
      endcase
    end
  end

  tfd_scan #(
    .TILE_WIDTH_SHIFT (TILE_WIDTH_SHIFT),
    .TILE_HEIGHT_SHIFT(TILE_HEIGHT_SHIFT),
    .STORE_BYTES      (STORE_BYTES)
  ) u_scan (
    .clk          (clk),
    .rst          (rst),
    .plane_mode   (plane_mode),
    .active_width (active_width),
    .active_height(active_height),
    .total_width  (total_width),
    .step         (step),
    .info         (info)
  );

  assign s2_leave   = s2_valid && (!result_valid || result_ready);
  // a write word retires from the address stage without going further
  assign s1_leave   = s1_valid && (s1_write || !s2_valid || s2_leave);
  assign s2_load    = s1_leave && !s1_write;
  assign item_ready = !s1_valid || s1_leave;
  assign item_take  = item_valid && item_ready;
  assign step       = item_take && (func == FUNC_READ);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item_take) begin
      s1_valid <= 1'b1;
    end else if (s1_leave) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_take) begin
      s1_write  <= (func == FUNC_WRITE);
      s1_data   <= write_data;
      s1_chroma <= plane_mode;
      s1_eor    <= info.eor;
      s1_eof    <= info.eof;
      if (func == FUNC_WRITE) begin
        s1_addr <= addr_t'(write_address);
        s1_oor  <= (addr_t'(write_address) >= addr_t'(STORE_BYTES));
      end else begin
        s1_addr <= info.addr;
        s1_oor  <= info.oor;
      end
    end
  end

  assign bank_addr = s1_addr[BANK_AW:1];
  assign even_we   = s1_leave && s1_write && !s1_oor && !s1_addr[0];
  assign odd_we    = s1_leave && s1_write && !s1_oor && s1_addr[0];
  assign bank_re   = s2_load && !s1_oor;

  tfd_ram #(
    .WIDTH(SAMPLE_W),
    .DEPTH(BANK_DEPTH)
  ) u_even_bank (
    .clk    (clk),
    .wr_en  (even_we),
    .wr_addr(bank_addr),
    .wr_data(s1_data),
    .rd_en  (bank_re),
    .rd_addr(bank_addr),
    .rd_data(even_q)
  );

  tfd_ram #(
    .WIDTH(SAMPLE_W),
    .DEPTH(BANK_DEPTH)
  ) u_odd_bank (
    .clk    (clk),
    .wr_en  (odd_we),
    .wr_addr(bank_addr),
    .wr_data(s1_data),
    .rd_en  (bank_re),
    .rd_addr(bank_addr),
    .rd_data(odd_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_load) begin
      s2_valid <= 1'b1;
    end else if (s2_leave) begin
      s2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load) begin
      s2_eor    <= s1_eor;
      s2_eof    <= s1_eof;
      s2_oor    <= s1_oor;
      s2_chroma <= s1_chroma;
      s2_lsb    <= s1_addr[0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s2_leave) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_leave) begin
      end_of_row   <= s2_eor;
      end_of_frame <= s2_eof;
      out_of_range <= s2_oor;
      if (s2_oor) begin
        first_sample  <= '0;
        second_sample <= '0;
      end else if (s2_chroma == MODE_CHROMA) begin
        first_sample  <= even_q;
        second_sample <= odd_q;
      end else begin
        first_sample  <= s2_lsb ? odd_q : even_q;
        second_sample <= '0;
      end
    end
  end

endmodule

// File: hw/rtl/tfd_checker.sv
// Port-level checks on the detiler's result channel, bound to the top level.
module tfd_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            result_valid,
  input logic                            result_ready,
  input logic [tfd_pkg::SAMPLE_W-1:0]    first_sample,
  input logic [tfd_pkg::SAMPLE_W-1:0]    second_sample,
  input logic                            end_of_row,
  input logic                            end_of_frame,
  input logic                            out_of_range
);

  // a stalled result word holds its samples and its end of frame flag
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(first_sample)
      && $stable(second_sample) && $stable(end_of_frame))
    else $error("result word changed while stalled");

  a_oor_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && out_of_range |-> first_sample == '0 && second_sample == '0)
    else $error("out of range word carries sample data");

  a_eof_eor: assert property (@(posedge clk) disable iff (rst)
    result_valid && end_of_frame |-> end_of_row)
    else $error("end of frame without end of row");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid right after reset");

endmodule

bind tiled_frame_detiler tfd_checker u_tfd_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .first_sample (first_sample),
  .second_sample(second_sample),
  .end_of_row   (end_of_row),
  .end_of_frame (end_of_frame),
  .out_of_range (out_of_range)
);

// File: test/tb_tiled_frame_detiler.sv
// Self-checking testbench for the tiled frame detiler: scoreboarded raster reads over a tiled store.
module tb_tiled_frame_detiler;
  timeunit 1ns;
  timeprecision 1ps;

  import tfd_pkg::*;

  localparam int TW_SHIFT = 8;
  localparam int TH_SHIFT = 5;
  localparam int STORE_SIZE = 1048576;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 12;

  typedef struct {
    logic                op;
    logic [WADDR_W-1:0]  addr;
    logic [SAMPLE_W-1:0] data;
  } scan_word_t;

  typedef struct {
    logic [SAMPLE_W-1:0] first;
    logic [SAMPLE_W-1:0] second;
    logic                eor;
    logic                eof;
    logic                oor;
  } pixel_out_t;

  typedef struct {
    int unsigned col;
    int unsigned row;
  } scan_pos_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   item_valid = 1'b0;
  logic                   item_ready;
  logic                   func = FUNC_WRITE;
  logic [WADDR_W-1:0]     write_address = '0;
  logic [SAMPLE_W-1:0]    write_data = '0;
  logic                   result_valid;
  logic                   result_ready = 1'b0;
  logic [SAMPLE_W-1:0]    first_sample;
  logic [SAMPLE_W-1:0]    second_sample;
  logic                   end_of_row;
  logic                   end_of_frame;
  logic                   out_of_range;

  // geometry registers as the block holds them
  logic        chroma_mode = MODE_LUMA;
  int unsigned width_reg = 32'(RESET_ACTIVE_WIDTH);
  int unsigned height_reg = 32'(RESET_ACTIVE_HEIGHT);
  int unsigned stride_reg = 32'(RESET_TOTAL_WIDTH);

  // scoreboard side
  scan_pos_t   live_pos = '{0, 0};
  logic [7:0]  pixel_store [int unsigned];
  pixel_out_t  pending_pixels [$];
  int unsigned mismatches = 0;

  // stimulus side
  scan_pos_t   plan_pos = '{0, 0};
  bit          planned [int unsigned];
  scan_word_t  scan_words [$];
  scan_word_t  held_word;
  bit          calm = 1'b0;
  int unsigned send_gap = 0;
  int unsigned stall_left = 0;
  int unsigned idle_cycles = 0;

  tiled_frame_detiler #(
    .TILE_WIDTH_SHIFT(TW_SHIFT),
    .TILE_HEIGHT_SHIFT(TH_SHIFT),
    .STORE_BYTES(STORE_SIZE)
  ) dut (.*);

  always #6 clk = ~clk;

  function automatic int unsigned clamp_dim(int unsigned v);
    if (v == 0) return 1;
    if (v > DIM_MAX) return 32'(DIM_MAX);
    return v;
  endfunction

  function automatic int unsigned tile_offset(int unsigned x, int unsigned y);
    int unsigned tile_w;
    int unsigned tile_h;
    tile_w = 1 << TW_SHIFT;
    tile_h = 1 << TH_SHIFT;
    return (x >> TW_SHIFT) * tile_w * tile_h + (y >> TH_SHIFT) * stride_reg * tile_h
      + (x & (tile_w - 1)) + (y & (tile_h - 1)) * tile_w;
  endfunction

  // chroma pairs sit at twice the column in bytes
  function automatic int unsigned pos_addr(scan_pos_t p);
    return tile_offset(chroma_mode ? p.col * 2 : p.col, p.row);
  endfunction

  // counters compare with >= so a geometry shrink mid-frame wraps on the next pixel
  function automatic scan_pos_t step_pos(scan_pos_t p, output logic eor, output logic eof);
    scan_pos_t n;
    eor = (p.col + 1 >= clamp_dim(width_reg));
    eof = eor && (p.row + 1 >= clamp_dim(height_reg));
    n = p;
    if (eor) begin
      n.col = 0;
      n.row = eof ? 0 : (p.row + 1) & 'hFFF;
    end else begin
      n.col = (p.col + 1) & 'hFFF;
    end
    return n;
  endfunction

  function automatic void detile_word(scan_word_t w);
    pixel_out_t  px;
    int unsigned a;
    logic        eor;
    logic        eof;
    if (w.op == FUNC_WRITE) begin
      if (w.addr < STORE_SIZE) pixel_store[w.addr] = w.data;
      return;
    end
    a = pos_addr(live_pos);
    px.first = '0;
    px.second = '0;
    px.oor = (a + chroma_mode >= STORE_SIZE);
    if (!px.oor) begin
      px.first = pixel_store[a];
      if (chroma_mode) px.second = pixel_store[a + 1];
    end
    live_pos = step_pos(live_pos, eor, eof);
    px.eor = eor;
    px.eof = eof;
    pending_pixels.push_back(px);
  endfunction

  function automatic void compare_field(string name, logic [SAMPLE_W-1:0] want,
                                        logic [SAMPLE_W-1:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10) $display("%s mismatch: expected %0h, got %0h", name, want, got);
    end
  endfunction

  function automatic void check_pixel();
    pixel_out_t want;
    if (pending_pixels.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected result word: first %0h second %0h eor %b eof %b oor %b",
                 first_sample, second_sample, end_of_row, end_of_frame, out_of_range);
      return;
    end
    want = pending_pixels.pop_front();
    compare_field("first_sample", want.first, first_sample);
    compare_field("second_sample", want.second, second_sample);
    compare_field("end_of_row", SAMPLE_W'(want.eor), SAMPLE_W'(end_of_row));
    compare_field("end_of_frame", SAMPLE_W'(want.eof), SAMPLE_W'(end_of_frame));
    compare_field("out_of_range", SAMPLE_W'(want.oor), SAMPLE_W'(out_of_range));
  endfunction

  function automatic void queue_write(int unsigned a, logic [SAMPLE_W-1:0] d);
    scan_word_t w;
    w.op = FUNC_WRITE;
    w.addr = WADDR_W'(a);
    w.data = d;
    scan_words.push_back(w);
    if (a < STORE_SIZE) planned[a] = 1'b1;
  endfunction

  // fills the bytes the next raster pixel needs, sometimes rewrites them just before the read
  function automatic void queue_read();
    scan_word_t  w;
    int unsigned a;
    int unsigned b;
    logic        eor;
    logic        eof;
    a = pos_addr(plan_pos);
    if (a + chroma_mode < STORE_SIZE) begin
      for (b = a; b <= a + chroma_mode; b++) begin
        if (!planned.exists(b) || $urandom_range(0, 7) == 0)
          queue_write(b, SAMPLE_W'($urandom));
      end
    end
    w.op = FUNC_READ;
    w.addr = WADDR_W'($urandom);
    w.data = SAMPLE_W'($urandom);
    scan_words.push_back(w);
    plan_pos = step_pos(plan_pos, eor, eof);
  endfunction

  function automatic void run_reads(int unsigned reads, int unsigned noise_pct);
    repeat (reads) begin
      while ($urandom_range(0, 99) < noise_pct)
        queue_write($urandom_range(0, 20'hFFFFF), SAMPLE_W'($urandom));
      queue_read();
    end
  endfunction

  task automatic settle();
    while (scan_words.size() != 0 || item_valid || pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    case (idx)
      CFG_PLANE_MODE:    chroma_mode = value[0];
      CFG_ACTIVE_WIDTH:  width_reg = 32'(value[DIM_W-1:0]);
      CFG_ACTIVE_HEIGHT: height_reg = 32'(value[DIM_W-1:0]);
      CFG_TOTAL_WIDTH:   stride_reg = 32'(value);
      default: ;
    endcase
  endtask

  task automatic set_geometry(logic mode, int unsigned w, int unsigned h, int unsigned stride);
    write_reg(CFG_PLANE_MODE, CFG_DATA_W'(mode));
    write_reg(CFG_ACTIVE_WIDTH, CFG_DATA_W'(w));
    write_reg(CFG_ACTIVE_HEIGHT, CFG_DATA_W'(h));
    write_reg(CFG_TOTAL_WIDTH, CFG_DATA_W'(stride));
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic random_phase(int unsigned reads);
    int unsigned w;
    int unsigned h;
    int unsigned stride;
    w = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 16383) : $urandom_range(0, 24);
    case ($urandom_range(0, 7))
      0:       h = $urandom_range(0, 16383);
      1, 2:    h = $urandom_range(30, 90);
      default: h = $urandom_range(0, 6);
    endcase
    stride = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16383) : $urandom_range(0, 3) * 256;
    set_geometry(1'($urandom_range(0, 1)), w, h, stride);
    run_reads(reads, 20);
    settle();
  endtask

  // item driver
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      if (item_valid && item_ready) detile_word(held_word);
      if (!item_valid || item_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          item_valid <= 1'b0;
        end else if (scan_words.size() > 0) begin
          held_word = scan_words.pop_front();
          item_valid <= 1'b1;
          func <= held_word.op;
          write_address <= held_word.addr;
          write_data <= held_word.data;
          if (!calm && $urandom_range(0, 9) == 0) send_gap = $urandom_range(1, 16);
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      if (result_valid && result_ready) check_pixel();
      if (stall_left > 0) begin
        stall_left--;
        result_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 11) == 0) begin
        stall_left = $urandom_range(1, 16) - 1;
        result_ready <= 1'b0;
      end else begin
        result_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (result_valid && result_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset geometry, extreme addresses and bytes
    queue_write(32'hFFFFF, 8'hFF);
    queue_write(32'h00000, 8'h00);
    queue_write(32'h55555, 8'hAA);
    queue_write(32'hAAAAA, 8'h55);
    run_reads(4, 0);
    settle();

    // zero width and height act as one, zero stride
    set_geometry(MODE_CHROMA, 0, 0, 0);
    run_reads(3, 0);
    settle();

    // small frame wraps, all config data bits high on the stride
    set_geometry(MODE_LUMA, 3, 2, 'h3FFF);
    run_reads(7, 0);
    settle();

    // one pair per row down past the end of the store; height saturates
    set_geometry(MODE_CHROMA, 1, 'h3FFF, 'h3FFF);
    run_reads(80, 10);
    settle();

    // width above the counter reach saturates, so a short run stays in one row
    set_geometry(MODE_LUMA, 'h3FFF, 2, 512);
    run_reads(24, 0);
    settle();

    repeat (4) random_phase($urandom_range(20, 45));

    calm = 1'b1;
    random_phase(40);

    if (mismatches == 0 && pending_pixels.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: tiled_frame_detiler.f
hw/rtl/tfd_pkg.sv
hw/rtl/tfd_ram.sv
hw/rtl/tfd_scan.sv
hw/rtl/tiled_frame_detiler.sv
hw/rtl/tfd_checker.sv
test/tb_tiled_frame_detiler.sv
